// File: sv/pws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic waveform sample package
// Shared widths, register and shape codes, pipeline structs, the
// quarter-wave sine table and the offset fraction table of the core.
// ----------------------------------------------------------------------------
package pws_pkg;

   // Sizing of the phase accumulator and the sine table.
   localparam int SINE_TABLE_BITS     = 10;
   localparam int PHASE_FRACTION_BITS = 32;
   localparam int ROM_DEPTH           = 2 ** SINE_TABLE_BITS + 1;

   // One full turn in Q9.8 degrees.
   localparam logic signed [18:0] DEG_TURN = 19'sd92160;

   // A turn is 45 times 2^11 in Q9.8 degrees, so the offset fraction splits
   // into a quotient by 45 and a table of the fractions of the remainder.
   localparam int           TURN_POW2_BITS     = 11;
   localparam int           OFFSET_DIVISOR     = 45;
   localparam int           REM_W              = $clog2(OFFSET_DIVISOR);
   localparam int           FRAC_W             = PHASE_FRACTION_BITS - TURN_POW2_BITS;
   localparam logic [17:0]  OFFSET_RECIP       = 18'd186414;
   localparam int           OFFSET_RECIP_SHIFT = 23;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_SHAPE_MODE = 2'd0;
   localparam logic [1:0] REG_AMPLITUDE  = 2'd1;
   localparam logic [1:0] REG_FREQUENCY  = 2'd2;
   localparam logic [1:0] REG_PHASE      = 2'd3;

   // Shape mode codes.
   localparam logic [2:0] MODE_SINE     = 3'd0;
   localparam logic [2:0] MODE_COSINE   = 3'd1;
   localparam logic [2:0] MODE_SQUARE   = 3'd2;
   localparam logic [2:0] MODE_TRIANGLE = 3'd3;
   localparam logic [2:0] MODE_SAWTOOTH = 3'd4;

   // Register reset values.
   localparam logic [2:0]         RST_SHAPE_MODE = MODE_SINE;
   localparam logic signed [15:0] RST_AMPLITUDE  = 16'sd16384;
   localparam logic [31:0]        RST_FREQUENCY  = 32'd65536;

   // Unit values in Q1.15 and the top table address.
   localparam logic signed [16:0] UNIT_POS = 17'sd32768;
   localparam logic signed [16:0] UNIT_NEG = -17'sd32768;
   localparam logic [SINE_TABLE_BITS:0] K_TOP =
      (SINE_TABLE_BITS + 1)'(2 ** SINE_TABLE_BITS);

   localparam longint Q30_ONE = 64'sd1073741824;

   typedef logic [SINE_TABLE_BITS:0] rom_addr_type;
   typedef logic [15:0] sine_rom_type [ROM_DEPTH];
   typedef logic [FRAC_W-1:0] frac_table_type [OFFSET_DIVISOR];

   // Request from the phase stages to the table stages.
   typedef struct packed {
      logic                valid;
      logic                is_sine;
      logic                negate;
      rom_addr_type        k;
      logic signed [16:0]  u_other;
   } shape_req_type;

   // Unit waveform value handed to the scaling stages.
   typedef struct packed {
      logic                valid;
      logic signed [16:0]  u;
   } unit_type;

   // Q30 product with truncating division.
   function automatic longint mul_q30(longint a, longint b);
      return (a * b) / Q30_ONE;
   endfunction

   // Quarter-wave sine table, evaluated at elaboration from an odd polynomial.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint x;
      longint x2;
      longint s;
      for (int k = 0; k < ROM_DEPTH; k++) begin
         x  = longint'(k) <<< (30 - SINE_TABLE_BITS);
         x2 = mul_q30(x, x);
         s  = -64'sd3864;
         s  = 64'sd172272 + mul_q30(s, x2);
         s  = -64'sd5026995 + mul_q30(s, x2);
         s  = 64'sd85569305 + mul_q30(s, x2);
         s  = -64'sd693598668 + mul_q30(s, x2);
         s  = 64'sd1686629713 + mul_q30(s, x2);
         s  = mul_q30(s, x);
         s  = (s + 64'sd16384) / 64'sd32768;
         if (s < 0) begin
            s = 0;
         end
         if (s > 64'sd32768) begin
            s = 64'sd32768;
         end
         rom[k] = 16'(s);
      end
      return rom;
   endfunction

   // Fraction of a turn for each remainder modulo 45, in the low phase bits.
   function automatic frac_table_type build_frac_table();
      frac_table_type tbl;
      for (int s = 0; s < OFFSET_DIVISOR; s++) begin
         tbl[s] = FRAC_W'((longint'(s) <<< FRAC_W) / OFFSET_DIVISOR);
      end
      return tbl;
   endfunction

   localparam sine_rom_type   SINE_ROM   = build_sine_rom();
   localparam frac_table_type FRAC_TABLE = build_frac_table();

endpackage

// File: sv/pws_offset_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase offset divider
// Converts the phase offset in degrees into a fraction of a turn in two
// register stages, by a reciprocal multiplication and a remainder table.
// ----------------------------------------------------------------------------
module pws_offset_div (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      load,
   input  logic signed [17:0]                        phase_deg,
   output logic [pws_pkg::PHASE_FRACTION_BITS-1:0]   offset,
   output logic                                      busy
);

   logic signed [18:0]                             pd_wide;
   logic signed [18:0]                             pd_red;
   logic [16:0]                                    r_ff;
   logic [34:0]                                    prod;
   logic [pws_pkg::TURN_POW2_BITS-1:0]             q_in;
   logic [pws_pkg::TURN_POW2_BITS-1:0]             q_ff;
   logic [16:0]                                    r2_ff;
   logic [16:0]                                    q45;
   logic [16:0]                                    rem_full;
   logic [pws_pkg::REM_W-1:0]                      rem;
   logic                                           v1_ff;
   logic                                           v2_ff;
   logic [pws_pkg::PHASE_FRACTION_BITS-1:0]        offset_in;
   logic [pws_pkg::PHASE_FRACTION_BITS-1:0]        offset_ff;

   // Reduce the offset into one turn, matching a truncating remainder.
   always_comb begin
      pd_wide = 19'(phase_deg);
      if (pd_wide < -pws_pkg::DEG_TURN) begin
         pd_red = pd_wide + pws_pkg::DEG_TURN + pws_pkg::DEG_TURN;
      end else if (pd_wide < 19'sd0) begin
         pd_red = pd_wide + pws_pkg::DEG_TURN;
      end else if (pd_wide >= pws_pkg::DEG_TURN) begin
         pd_red = pd_wide - pws_pkg::DEG_TURN;
      end else begin
         pd_red = pd_wide;
      end
   end

   // First stage: quotient of the reduced offset by 45, exact below a turn.
   assign prod = 35'(r_ff) * 35'(pws_pkg::OFFSET_RECIP);
   assign q_in = prod[pws_pkg::OFFSET_RECIP_SHIFT +: pws_pkg::TURN_POW2_BITS];

   // Second stage: remainder by 45 selects the low fraction bits.
   assign q45       = 17'(q_ff) * 17'(pws_pkg::OFFSET_DIVISOR);
   assign rem_full  = r2_ff - q45;
   assign rem       = rem_full[pws_pkg::REM_W-1:0];
   assign offset_in = {q_ff, pws_pkg::FRAC_TABLE[rem]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         offset_ff <= '0;
      end else begin
         v1_ff <= load;
         v2_ff <= v1_ff;
         if (v2_ff) begin
            offset_ff <= offset_in;
         end
      end
   end

   // Intermediate registers carry payload only.
   always_ff @(posedge clock) begin
      if (load) begin
         r_ff <= 17'(pd_red);
      end
      if (v1_ff) begin
         q_ff  <= q_in;
         r2_ff <= r_ff;
      end
   end

   assign offset = offset_ff;
   assign busy   = v1_ff || v2_ff;

endmodule

// File: sv/pws_phase_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase generator stages
// Registers the sample time, forms frequency times time, adds the phase
// offset and decodes the phase into a table address or a direct shape value.
// ----------------------------------------------------------------------------
module pws_phase_gen (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   input  logic [31:0]                               sample_time,
   input  logic [31:0]                               frequency,
   input  logic [pws_pkg::PHASE_FRACTION_BITS-1:0]   offset,
   input  logic [2:0]                                shape_mode,
   output pws_pkg::shape_req_type                    shape_req
);

   localparam int P = pws_pkg::PHASE_FRACTION_BITS;
   localparam int B = pws_pkg::SINE_TABLE_BITS;

   logic                      s0_valid_ff;
   logic [31:0]               s0_time_ff;
   logic                      s1_valid_ff;
   logic [31:0]               s1_tf_ff;
   logic [31:0]               tf_in;
   logic [P+31:0]             tf_wide;
   logic [P-1:0]              ph;
   logic [P+16:0]             ph_tri;
   logic [P+15:0]             ph_saw;
   logic [16:0]               g;
   logic signed [17:0]        g_s;
   logic [15:0]               s16;
   logic [1:0]                quad;
   logic [B-1:0]              idx;
   pws_pkg::shape_req_type    req_in;
   pws_pkg::shape_req_type    req_ff;

   // Stage 0: capture the accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= in_valid;
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_time_ff <= sample_time;
      s1_tf_ff   <= tf_in;
   end

   // Stage 1: low word of frequency times time is the phase in Q0.32 turns.
   assign tf_in = frequency * s0_time_ff;

   // Stage 2: scale to the phase width and add the offset modulo one turn.
   assign tf_wide = {s1_tf_ff, {P{1'b0}}};
   assign ph      = tf_wide[P+31:32] + offset;
   assign ph_tri  = {ph, 17'b0};
   assign ph_saw  = {ph, 16'b0};
   assign g       = ph_tri[P+16:P];
   assign g_s     = $signed({1'b0, g});
   assign s16     = ph_saw[P+15:P];
   assign idx     = ph[P-3 -: B];

   // Decode the shape mode into a table request or a direct value.
   always_comb begin
      quad           = ph[P-1:P-2];
      req_in.valid   = s1_valid_ff;
      req_in.is_sine = 1'b0;
      req_in.u_other = '0;
      case (shape_mode)
         pws_pkg::MODE_SINE: begin
            req_in.is_sine = 1'b1;
         end
         pws_pkg::MODE_COSINE: begin
            req_in.is_sine = 1'b1;
            quad           = ph[P-1:P-2] + 2'd1;
         end
         pws_pkg::MODE_SQUARE: begin
            req_in.u_other = ph[P-1] ? pws_pkg::UNIT_NEG : pws_pkg::UNIT_POS;
         end
         pws_pkg::MODE_TRIANGLE: begin
            if (g_s < 18'sd32768) begin
               req_in.u_other = 17'(g_s);
            end else if (g_s < 18'sd98304) begin
               req_in.u_other = 17'(18'sd65536 - g_s);
            end else begin
               req_in.u_other = 17'(g_s - 18'sd131072);
            end
         end
         pws_pkg::MODE_SAWTOOTH: begin
            req_in.u_other = $signed({1'b0, s16}) - pws_pkg::UNIT_POS;
         end
         default: begin
            req_in.u_other = '0;
         end
      endcase
      req_in.negate = quad[1];
      if (quad[0]) begin
         req_in.k = pws_pkg::K_TOP - {1'b0, idx};
      end else begin
         req_in.k = {1'b0, idx};
      end
   end

   // Only the valid bit is reset; the rest of the request is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff.valid <= 1'b0;
      end else begin
         req_ff.valid <= req_in.valid;
      end
      req_ff.is_sine <= req_in.is_sine;
      req_ff.negate  <= req_in.negate;
      req_ff.k       <= req_in.k;
      req_ff.u_other <= req_in.u_other;
   end

   assign shape_req = req_ff;

endmodule

// File: sv/pws_shape_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shape table stages
// Reads the quarter-wave sine table with a registered read, then applies
// the quadrant sign and selects between the sine and the direct shapes.
// ----------------------------------------------------------------------------
module pws_shape_rom (
   input  logic                    clock,
   input  logic                    reset,
   input  pws_pkg::shape_req_type  shape_req,
   output pws_pkg::unit_type       unit
);

   logic               s3_valid_ff;
   logic               s3_is_sine_ff;
   logic               s3_negate_ff;
   logic signed [16:0] s3_u_other_ff;
   logic [15:0]        rom_q_ff;
   logic signed [16:0] sine_val;
   logic               s4_valid_ff;
   logic signed [16:0] u_in;
   logic signed [16:0] u_ff;

   // Stage 3: table read, with side information carried alongside.
   always_ff @(posedge clock) begin
      rom_q_ff      <= pws_pkg::SINE_ROM[shape_req.k];
      s3_is_sine_ff <= shape_req.is_sine;
      s3_negate_ff  <= shape_req.negate;
      s3_u_other_ff <= shape_req.u_other;
   end

   // Stage 4: sign the table value for the lower half turn and choose the shape.
   assign sine_val = $signed({1'b0, rom_q_ff});

   always_comb begin
      if (s3_is_sine_ff) begin
         u_in = s3_negate_ff ? -sine_val : sine_val;
      end else begin
         u_in = s3_u_other_ff;
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= shape_req.valid;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   assign unit.valid = s4_valid_ff;
   assign unit.u     = u_ff;

endmodule

// File: sv/pws_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Amplitude scaling stages
// Multiplies the unit waveform by the amplitude, then rounds half up to
// the output scale and saturates to 16 bits.
// ----------------------------------------------------------------------------
module pws_scale (
   input  logic                clock,
   input  logic                reset,
   input  pws_pkg::unit_type   unit,
   input  logic signed [15:0]  amplitude,
   output logic                out_valid,
   output logic signed [15:0]  out_value
);

   logic               s5_valid_ff;
   logic signed [32:0] prod_in;
   logic signed [32:0] prod_ff;
   logic signed [33:0] rnd_sum;
   logic signed [33:0] rnd_shift;
   logic signed [15:0] value_in;
   logic signed [15:0] value_ff;
   logic               valid_ff;

   // Stage 5: signed product of amplitude and unit value.
   assign prod_in = 33'(amplitude) * 33'(unit.u);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Stage 6: round half up by the Q1.15 scale and saturate.
   assign rnd_sum   = 34'(prod_ff) + 34'sd16384;
   assign rnd_shift = rnd_sum >>> 15;

   always_comb begin
      if (rnd_shift > 34'sd32767) begin
         value_in = 16'sh7FFF;
      end else if (rnd_shift < -34'sd32768) begin
         value_in = -16'sd32768;
      end else begin
         value_in = 16'(rnd_shift);
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         s5_valid_ff <= unit.valid;
         valid_ff    <= s5_valid_ff;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;

endmodule

// File: sv/periodic_waveform_sample_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic waveform sample core
// Stateless function generator: turns a sample time into one sine, cosine,
// square, triangle or sawtooth sample, scaled by the amplitude register.
// ----------------------------------------------------------------------------
// The core takes one sample-time transaction every clock while busy is low
// and returns each result as a single-cycle rsp_valid strobe; the result
// side has no backpressure, so the receiver must take every strobe. The
// pipeline has seven register stages (input, multiplier, phase decode,
// table read, sign select, amplitude multiplier, rounding). Writing the
// phase register starts a two-stage conversion of the offset into a
// fraction of a turn: busy and a low csr_ready then hold while it runs,
// and no transaction is taken until busy falls.
module periodic_waveform_sample_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [31:0]         req_sample_time,
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_sample_value,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata
);

   logic [2:0]                                   shape_mode_ff;
   logic signed [15:0]                           amplitude_ff;
   logic [31:0]                                  frequency_ff;
   logic                                         csr_wr;
   logic                                         phase_load;
   logic                                         div_busy;
   logic [pws_pkg::PHASE_FRACTION_BITS-1:0]      offset;
   logic                                         in_valid;
   pws_pkg::shape_req_type                       shape_req;
   pws_pkg::unit_type                            unit;

   // Configuration transactions are held off while the divider runs.
   assign csr_ready  = !div_busy;
   assign csr_wr     = csr_valid && csr_ready;
   assign phase_load = csr_wr && (csr_index == pws_pkg::REG_PHASE);
   assign busy       = div_busy;
   assign in_valid   = start && !div_busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         shape_mode_ff <= pws_pkg::RST_SHAPE_MODE;
         amplitude_ff  <= pws_pkg::RST_AMPLITUDE;
         frequency_ff  <= pws_pkg::RST_FREQUENCY;
      end else if (csr_wr) begin
         case (csr_index)
            pws_pkg::REG_SHAPE_MODE: begin
               shape_mode_ff <= csr_wdata[2:0];
            end
            pws_pkg::REG_AMPLITUDE: begin
               amplitude_ff <= $signed(csr_wdata[15:0]);
            end
            pws_pkg::REG_FREQUENCY: begin
               frequency_ff <= csr_wdata;
            end
            default: begin
               // The phase register lives in the offset divider.
            end
         endcase
      end
   end

   pws_offset_div u_offset_div (
      .clock     (clock),
      .reset     (reset),
      .load      (phase_load),
      .phase_deg ($signed(csr_wdata[17:0])),
      .offset    (offset),
      .busy      (div_busy)
   );

   pws_phase_gen u_phase_gen (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (in_valid),
      .sample_time (req_sample_time),
      .frequency   (frequency_ff),
      .offset      (offset),
      .shape_mode  (shape_mode_ff),
      .shape_req   (shape_req)
   );

   pws_shape_rom u_shape_rom (
      .clock     (clock),
      .reset     (reset),
      .shape_req (shape_req),
      .unit      (unit)
   );

   pws_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .unit      (unit),
      .amplitude (amplitude_ff),
      .out_valid (rsp_valid),
      .out_value (rsp_sample_value)
   );

endmodule

// File: sv/pws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic waveform sample checker
// Port-level assertions on latency, the busy window and reset behaviour,
// bound to the core.
// ----------------------------------------------------------------------------
module pws_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        rsp_valid,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index
);

   // Every accepted transaction yields a result.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##7 rsp_valid)
      else $error("accepted transaction produced no result");

   // No result appears without a matching accepted transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 7))
      else $error("result without a matching transaction");

   // A phase write starts the offset divider.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == pws_pkg::REG_PHASE) |=> busy)
      else $error("phase write did not raise busy");

   // The pipeline is empty straight after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("result or busy seen just after reset");

endmodule

bind periodic_waveform_sample_core pws_checker u_pws_checker (.*);

// File: tb/sv/periodic_waveform_sample_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic waveform sample core testbench
// Drives sample-time transactions into the core under a range of shape,
// amplitude, frequency and phase settings. Every returned sample is checked
// against a golden value or a model of the phase, shape and scaling arithmetic.
// ----------------------------------------------------------------------------
module periodic_waveform_sample_core_test;

   // Pipeline depth of the core, used when letting it settle.
   localparam int PIPE_LATENCY = 7;
   localparam int RANDOM_ITEMS = 1000;
   localparam int QUIET_FROM   = 840;
   localparam int MAX_REPORTS  = 10;
   localparam int TURN_Q8      = 92160;
   localparam int TABLE_TOP    = 2 ** pws_pkg::SINE_TABLE_BITS;

   // Shape codes that select no waveform.
   localparam logic [2:0] MODE_SPARE_A = 3'd5;
   localparam logic [2:0] MODE_SPARE_B = 3'd6;
   localparam logic [2:0] MODE_SPARE_C = 3'd7;

   // One row of the directed stimulus: raw register words, the sample time
   // and, where it is obvious, the sample that must come back.
   typedef struct packed {
      logic [31:0]        mode_w;
      logic [31:0]        amp_w;
      logic [31:0]        freq_w;
      logic [31:0]        phase_w;
      logic [31:0]        t;
      logic               checked;
      logic signed [15:0] golden;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 26;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [31:0]        req_sample_time;
   logic               rsp_valid;
   logic signed [15:0] rsp_sample_value;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [31:0]        csr_wdata;

   // Register copies held by the model.
   logic [2:0]         mode_reg;
   logic signed [15:0] amp_reg;
   logic [31:0]        freq_reg;
   logic signed [17:0] phase_reg;
   logic [31:0]        csr_shadow [4];

   int                 sine_quarter [0:TABLE_TOP];
   logic signed [15:0] expected_samples [$];

   int fails;
   int samples_sent;
   int samples_checked;
   int csr_writes;
   int settings_used;

   stim_row_type directed [DIRECTED_ROWS] = '{
      // Reset settings: sine, half amplitude, one hertz, no offset.
      '{{29'd0, pws_pkg::MODE_SINE}, 32'h0000_4000, 32'd65536, 32'd0, 32'h0000_0000,
        1'b1, 16'sd0},
      '{{29'd0, pws_pkg::MODE_SINE}, 32'h0000_4000, 32'd65536, 32'd0, 32'h0000_4000,
        1'b1, 16'sd16384},
      '{{29'd0, pws_pkg::MODE_SINE}, 32'h0000_4000, 32'd65536, 32'd0, 32'h0000_2000,
        1'b0, 16'sd0},
      '{{29'd0, pws_pkg::MODE_SINE}, 32'h0000_4000, 32'd65536, 32'd0, 32'hFFFF_FFFF,
        1'b0, 16'sd0},
      // Cosine leads by a quarter turn.
      '{{29'd0, pws_pkg::MODE_COSINE}, 32'h0000_4000, 32'd65536, 32'd0, 32'h0000_0000,
        1'b1, 16'sd16384},
      '{{29'd0, pws_pkg::MODE_COSINE}, 32'h0000_4000, 32'd65536, 32'd0, 32'h0000_6000,
        1'b0, 16'sd0},
      // Square at both amplitude extremes, with junk in the upper register bits.
      '{{29'h1FFF_FFFF, pws_pkg::MODE_SQUARE}, 32'h1234_7FFF, 32'd65536, 32'd0,
        32'h0000_0000, 1'b1, 16'sd32767},
      '{{29'h1FFF_FFFF, pws_pkg::MODE_SQUARE}, 32'h1234_7FFF, 32'd65536, 32'd0,
        32'h0000_8000, 1'b1, -16'sd32767},
      // Minus full scale times minus one saturates.
      '{{29'h1FFF_FFFF, pws_pkg::MODE_SQUARE}, 32'hFFFF_8000, 32'd65536, 32'd0,
        32'h0000_8000, 1'b1, 16'sd32767},
      '{{29'h1FFF_FFFF, pws_pkg::MODE_SQUARE}, 32'hFFFF_8000, 32'd65536, 32'd0,
        32'h0000_0000, 1'b1, -16'sd32768},
      // Triangle peaks and a point on the falling slope.
      '{{29'd0, pws_pkg::MODE_TRIANGLE}, 32'h0000_4000, 32'd65536, 32'd0, 32'h0000_4000,
        1'b1, 16'sd16384},
      '{{29'd0, pws_pkg::MODE_TRIANGLE}, 32'h0000_4000, 32'd65536, 32'd0, 32'h0000_C000,
        1'b1, -16'sd16384},
      '{{29'd0, pws_pkg::MODE_TRIANGLE}, 32'h0000_4000, 32'd65536, 32'd0, 32'h0000_6000,
        1'b0, 16'sd0},
      // Sawtooth start and end of the turn.
      '{{29'd0, pws_pkg::MODE_SAWTOOTH}, 32'h0000_4000, 32'd65536, 32'd0, 32'h0000_0000,
        1'b1, -16'sd16384},
      '{{29'd0, pws_pkg::MODE_SAWTOOTH}, 32'h0000_4000, 32'd65536, 32'd0, 32'h0000_FFFF,
        1'b0, 16'sd0},
      // Unused shape codes give silence.
      '{{29'd0, MODE_SPARE_A}, 32'h0000_4000, 32'd65536, 32'd0, 32'h0000_1234, 1'b1, 16'sd0},
      '{{29'd0, MODE_SPARE_B}, 32'h0000_7FFF, 32'd65536, 32'd0, 32'h0000_4000, 1'b1, 16'sd0},
      '{{29'd0, MODE_SPARE_C}, 32'hFFFF_8000, 32'd65536, 32'd0, 32'h0000_4000, 1'b1, 16'sd0},
      // Phase offsets: a quarter turn, whole turns either way, field extremes.
      '{{29'd0, pws_pkg::MODE_SINE}, 32'h0000_4000, 32'd65536, 32'h0000_5A00, 32'h0000_0000,
        1'b1, 16'sd16384},
      '{{29'd0, pws_pkg::MODE_SINE}, 32'h0000_4000, 32'd65536, 32'hFFFE_9800, 32'h0000_0000,
        1'b1, 16'sd0},
      '{{29'd0, pws_pkg::MODE_SINE}, 32'h0000_4000, 32'd65536, 32'h0001_6800, 32'h0000_0000,
        1'b1, 16'sd0},
      '{{29'd0, pws_pkg::MODE_SINE}, 32'h0000_4000, 32'd65536, 32'h0001_FFFF, 32'h0000_1000,
        1'b0, 16'sd0},
      '{{29'd0, pws_pkg::MODE_SINE}, 32'h0000_4000, 32'd65536, 32'h0002_0000, 32'h0000_1000,
        1'b0, 16'sd0},
      // Frequency extremes and a zero amplitude.
      '{{29'd0, pws_pkg::MODE_SINE}, 32'h0000_4000, 32'd0, 32'd0, 32'hFFFF_FFFF,
        1'b1, 16'sd0},
      '{{29'd0, pws_pkg::MODE_SINE}, 32'h0000_4000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 1'b0, 16'sd0},
      '{{29'd0, pws_pkg::MODE_SINE}, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h1234_5678, 1'b1, 16'sd0}
   };

   periodic_waveform_sample_core u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_time  (req_sample_time),
      .rsp_valid        (rsp_valid),
      .rsp_sample_value (rsp_sample_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 100 MHz clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Quarter-wave sine table from the odd degree-11 polynomial in Q30.
   initial begin
      longint coef [6];
      longint x;
      longint x2;
      longint acc;
      coef = '{64'sd1686629713, -64'sd693598668, 64'sd85569305,
               -64'sd5026995, 64'sd172272, -64'sd3864};
      for (int k = 0; k <= TABLE_TOP; k++) begin
         x   = longint'(k) <<< (30 - pws_pkg::SINE_TABLE_BITS);
         x2  = (x * x) / pws_pkg::Q30_ONE;
         acc = coef[5];
         for (int i = 4; i >= 0; i--) begin
            acc = coef[i] + (acc * x2) / pws_pkg::Q30_ONE;
         end
         acc = (acc * x) / pws_pkg::Q30_ONE;
         acc = (acc + 64'sd16384) / 64'sd32768;
         if (acc < 0) begin
            acc = 0;
         end
         if (acc > 64'sd32768) begin
            acc = 64'sd32768;
         end
         sine_quarter[k] = int'(acc);
      end
   end

   // Signed sine in Q1.15 units for a 32-bit phase in turns.
   function automatic int sine_at(logic [31:0] ph);
      logic [1:0]                          quad;
      logic [pws_pkg::SINE_TABLE_BITS-1:0] idx;
      int                                  k;
      quad = ph[31:30];
      idx  = ph[29:30-pws_pkg::SINE_TABLE_BITS];
      k    = quad[0] ? TABLE_TOP - int'(idx) : int'(idx);
      return quad[1] ? -sine_quarter[k] : sine_quarter[k];
   endfunction

   // Sample value for one sample time under the current register settings.
   function automatic logic signed [15:0] waveform_sample(logic [31:0] t);
      logic [31:0] ph;
      int          r;
      longint      offset;
      int          u;
      int          g;
      longint      y;
      r = int'(phase_reg) % TURN_Q8;
      if (r < 0) begin
         r = r + TURN_Q8;
      end
      offset = (longint'(r) <<< 32) / TURN_Q8;
      ph     = freq_reg * t;
      ph     = ph + offset[31:0];
      g      = int'(ph[31:15]);
      case (mode_reg)
         pws_pkg::MODE_SINE:     u = sine_at(ph);
         pws_pkg::MODE_COSINE:   u = sine_at(ph + 32'h4000_0000);
         pws_pkg::MODE_SQUARE:   u = ph[31] ? -32768 : 32768;
         pws_pkg::MODE_TRIANGLE: begin
            if (g < 32768) begin
               u = g;
            end else if (g < 98304) begin
               u = 65536 - g;
            end else begin
               u = g - 131072;
            end
         end
         pws_pkg::MODE_SAWTOOTH: u = int'(ph[31:16]) - 32768;
         default:                u = 0;
      endcase
      y = (longint'(amp_reg) * longint'(u) + 64'sd16384) >>> 15;
      if (y > 32767) begin
         y = 32767;
      end else if (y < -32768) begin
         y = -32768;
      end
      return y[15:0];
   endfunction

   // Write one register over the configuration port and track it in the model.
   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pws_pkg::REG_SHAPE_MODE: mode_reg  = data[2:0];
         pws_pkg::REG_AMPLITUDE:  amp_reg   = data[15:0];
         pws_pkg::REG_FREQUENCY:  freq_reg  = data;
         pws_pkg::REG_PHASE:      phase_reg = data[17:0];
         default: ;
      endcase
      csr_shadow[idx] = data;
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Present one sample time and record the expected sample once it is taken.
   task automatic send_sample(logic [31:0] t, bit use_golden, logic signed [15:0] golden);
      @(negedge clock);
      start           = 1'b1;
      req_sample_time = t;
      do @(posedge clock); while (busy);
      expected_samples.push_back(use_golden ? golden : waveform_sample(t));
      samples_sent++;
   endtask

   // Drop start for a random number of cycles.
   task automatic idle_gap();
      int n;
      n = $urandom_range(1, 17);
      @(negedge clock);
      start = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Stop issuing and let every outstanding sample come back.
   task automatic drain_core();
      @(negedge clock);
      start = 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   function automatic logic [31:0] random_time();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom_range(0, 65535);
         default: return $urandom;
      endcase
   endfunction

   // Pick a fresh setting for some of the registers, always at least one.
   task automatic reprogram();
      logic [31:0] junk;
      logic [31:0] word;
      int          first;
      first = $urandom_range(0, 3);
      for (int idx = 0; idx < 4; idx++) begin
         if (idx == first || $urandom_range(0, 1) == 1) begin
            junk = $urandom;
            case (idx)
               pws_pkg::REG_SHAPE_MODE: begin
                  word = {junk[31:3], ($urandom_range(0, 9) < 8) ?
                          3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7))};
               end
               pws_pkg::REG_AMPLITUDE: begin
                  case ($urandom_range(0, 7))
                     0:       word = {junk[31:16], 16'h8000};
                     1:       word = {junk[31:16], 16'h7FFF};
                     2:       word = {junk[31:16], 16'h0000};
                     3:       word = {junk[31:16], 16'hFFFF};
                     default: word = junk;
                  endcase
               end
               pws_pkg::REG_FREQUENCY: begin
                  case ($urandom_range(0, 7))
                     0:       word = 32'h0000_0000;
                     1:       word = 32'hFFFF_FFFF;
                     2:       word = 32'h0001_0000;
                     3:       word = $urandom_range(1, 32'h000F_FFFF);
                     default: word = junk;
                  endcase
               end
               default: begin
                  case ($urandom_range(0, 9))
                     0:       word = {junk[31:18], 18'h16800};
                     1:       word = {junk[31:18], 18'h29800};
                     2:       word = {junk[31:18], 18'h20000};
                     3:       word = {junk[31:18], 18'h1FFFF};
                     4:       word = {junk[31:18], 18'h00000};
                     default: word = junk;
                  endcase
               end
            endcase
            write_csr(2'(idx), word);
         end
      end
      settings_used++;
   endtask

   // Every strobe is compared with the oldest outstanding sample.
   always @(posedge clock) begin
      logic signed [15:0] want;
      if (!reset && rsp_valid) begin
         if (expected_samples.size() == 0) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
               $display("%0t: unexpected sample %0d with none outstanding",
                        $realtime, rsp_sample_value);
            end
         end else begin
            want = expected_samples.pop_front();
            samples_checked++;
            if (rsp_sample_value !== want) begin
               fails++;
               if (fails <= MAX_REPORTS) begin
                  $display("%0t: sample_value mismatch, expected %0d, got %0d",
                           $realtime, want, rsp_sample_value);
               end
            end
         end
      end
   end

   // Stimulus.
   initial begin
      int          sent_random;
      int          burst;
      bit          quiet;
      logic [31:0] want_w [4];
      reset           = 1'b1;
      start           = 1'b0;
      req_sample_time = '0;
      csr_valid       = 1'b0;
      csr_index       = pws_pkg::REG_SHAPE_MODE;
      csr_wdata       = '0;
      fails           = 0;
      samples_sent    = 0;
      samples_checked = 0;
      csr_writes      = 0;
      settings_used   = 1;
      mode_reg        = pws_pkg::RST_SHAPE_MODE;
      amp_reg         = pws_pkg::RST_AMPLITUDE;
      freq_reg        = pws_pkg::RST_FREQUENCY;
      phase_reg       = '0;
      csr_shadow      = '{{29'd0, pws_pkg::RST_SHAPE_MODE}, 32'(pws_pkg::RST_AMPLITUDE),
                          pws_pkg::RST_FREQUENCY, 32'd0};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed rows: rewrite only the registers that change, while idle.
      foreach (directed[i]) begin
         want_w = '{directed[i].mode_w, directed[i].amp_w,
                    directed[i].freq_w, directed[i].phase_w};
         if (want_w != csr_shadow) begin
            drain_core();
            for (int idx = 0; idx < 4; idx++) begin
               if (want_w[idx] != csr_shadow[idx]) begin
                  write_csr(2'(idx), want_w[idx]);
               end
            end
            settings_used++;
         end
         send_sample(directed[i].t, directed[i].checked, directed[i].golden);
      end

      // Random settings, each followed by a run of random sample times.
      sent_random = 0;
      while (sent_random < RANDOM_ITEMS) begin
         drain_core();
         reprogram();
         burst = $urandom_range(15, 60);
         for (int n = 0; n < burst; n++) begin
            quiet = (sent_random >= QUIET_FROM);
            send_sample(random_time(), 1'b0, '0);
            sent_random++;
            if (!quiet && $urandom_range(0, 3) == 0) begin
               idle_gap();
            end
         end
      end

      drain_core();
      repeat (PIPE_LATENCY + 3) @(posedge clock);
      $display("Sent %0d sample-time transactions and checked %0d samples.",
               samples_sent, samples_checked);
      $display("Covered %0d register settings through %0d register writes.",
               settings_used, csr_writes);
      if (fails == 0 && expected_samples.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
